/* src/svpwm_phase_duty_generator_core_defines.svh */
// Assertion macros shared by the SVPWM duty generator RTL.
`ifndef SVPWM_PHASE_DUTY_GENERATOR_CORE_DEFINES_SVH
`define SVPWM_PHASE_DUTY_GENERATOR_CORE_DEFINES_SVH

// Checked property that is ignored while reset is asserted.
`define SVPWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked property that also holds during reset.
`define SVPWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* src/svpwm_pkg.sv */
// Shared constants, types and the sine table builder for the SVPWM duty generator.
package svpwm_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam int ANGLE_BITS_DEF       = 16;
    localparam int DUTY_BITS_DEF        = 16;

    localparam int REQ_W    = 17;
    localparam int SINE_W   = 16;
    localparam int SUM_W    = 17;
    localparam int FACTOR_W = 18;
    localparam int CLAMP_W  = 16;
    localparam int CFG_W    = 16;

    localparam logic [63:0] PI_THIRD_Q30 = 64'd1124419809;
    localparam logic [FACTOR_W-1:0] HALF_Q17 = 18'd65536;
    localparam logic [FACTOR_W-1:0] ONE_Q17  = 18'd131072;

    typedef logic [2:0] sector_t;
    localparam sector_t SECTOR_I   = 3'd0;
    localparam sector_t SECTOR_II  = 3'd1;
    localparam sector_t SECTOR_III = 3'd2;
    localparam sector_t SECTOR_IV  = 3'd3;
    localparam sector_t SECTOR_V   = 3'd4;
    localparam sector_t SECTOR_VI  = 3'd5;

    typedef logic cfg_index_t;
    localparam cfg_index_t REG_ENABLE   = 1'b0;
    localparam cfg_index_t REG_MAX_DUTY = 1'b1;

    // Sine of x (pi/3 scaled, Q30) by a five-term Taylor series, rounded to Q16.
    function automatic logic [SINE_W-1:0] sine_from_x(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] rnd;
        x2  = (x * x) >> 30;
        t   = x;
        s   = x;
        t   = ((t * x2) >> 30) / 64'd6;
        s   = s - t;
        t   = ((t * x2) >> 30) / 64'd20;
        s   = s + t;
        t   = ((t * x2) >> 30) / 64'd42;
        s   = s - t;
        t   = ((t * x2) >> 30) / 64'd72;
        s   = s + t;
        rnd = (s + 64'd8192) >> 14;
        return rnd[SINE_W-1:0];
    endfunction

endpackage

/* src/svpwm_angle_stage.sv */
// First pipeline stage: sector and in-sector angle, duty request clamp.
module svpwm_angle_stage import svpwm_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int DUTY_BITS  = DUTY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ANGLE_BITS-1:0] angle_in,
    input  logic [REQ_W-1:0]      duty_request,
    input  logic [CLAMP_W-1:0]    max_duty,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sector_t               sector,
    output logic [ANGLE_BITS-1:0] theta_rem,
    output logic [CLAMP_W-1:0]    duty_clamped
);

    localparam int SIX_W   = ANGLE_BITS + 3;
    localparam int DMAX_I  = (DUTY_BITS >= CLAMP_W) ? ((1 << CLAMP_W) - 1)
                                                    : ((1 << DUTY_BITS) - 1);
    localparam logic [CLAMP_W-1:0] DUTY_LIMIT = CLAMP_W'(DMAX_I);

    logic                  valid_reg;
    sector_t               sector_reg, sector_next;
    logic [ANGLE_BITS-1:0] rem_reg, rem_next;
    logic [CLAMP_W-1:0]    duty_reg, duty_next;
    logic [SIX_W-1:0]      six;
    logic [CLAMP_W-1:0]    duty_pos;
    logic [CLAMP_W-1:0]    duty_cap;

    assign six         = SIX_W'(angle_in) * SIX_W'(6);
    assign sector_next = six[ANGLE_BITS +: 3];
    assign rem_next    = six[ANGLE_BITS-1:0];

    always_comb begin
        duty_pos  = duty_request[REQ_W-1] ? '0 : duty_request[CLAMP_W-1:0];
        duty_cap  = (duty_pos > max_duty) ? max_duty : duty_pos;
        duty_next = (duty_cap > DUTY_LIMIT) ? DUTY_LIMIT : duty_cap;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sector_reg <= sector_next;
            rem_reg    <= rem_next;
            duty_reg   <= duty_next;
        end
    end

    assign out_valid    = valid_reg;
    assign sector       = sector_reg;
    assign theta_rem    = rem_reg;
    assign duty_clamped = duty_reg;

endmodule

/* src/svpwm_sine_lookup.sv */
// Second pipeline stage: sine table lookups for the two half-sine terms.
module svpwm_sine_lookup import svpwm_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int ANGLE_BITS       = ANGLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sector_t               sector_in,
    input  logic [ANGLE_BITS-1:0] theta_rem,
    input  logic [CLAMP_W-1:0]    duty_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sector_t               sector_out,
    output logic [SINE_W-1:0]     term_a,
    output logic [SINE_W-1:0]     term_b,
    output logic [CLAMP_W-1:0]    duty_out
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = ANGLE_BITS + 1 + IDX_W;
    localparam logic [PROD_W-1:0] FULL_TURN = PROD_W'(1) << ANGLE_BITS;

    logic [SINE_W-1:0]  sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
        localparam logic [63:0] X = (64'(i) * PI_THIRD_Q30) / 64'(SINE_TABLE_DEPTH);
        assign sine_rom[i] = sine_from_x(X);
    end

    logic                 valid_reg;
    sector_t              sector_reg;
    logic [SINE_W-1:0]    a_reg, a_next;
    logic [SINE_W-1:0]    b_reg, b_next;
    logic [CLAMP_W-1:0]   duty_reg;
    logic [PROD_W-1:0]    pos_a;
    logic [PROD_W-1:0]    prod_a;
    logic [PROD_W-1:0]    prod_b;
    logic [IDX_W-1:0]     idx_a;
    logic [IDX_W-1:0]     idx_b;

    assign pos_a  = FULL_TURN - PROD_W'(theta_rem);
    assign prod_a = pos_a * PROD_W'(SINE_TABLE_DEPTH);
    assign prod_b = PROD_W'(theta_rem) * PROD_W'(SINE_TABLE_DEPTH);
    assign idx_a  = prod_a[ANGLE_BITS +: IDX_W];
    assign idx_b  = prod_b[ANGLE_BITS +: IDX_W];
    assign a_next = sine_rom[idx_a];
    assign b_next = sine_rom[idx_b];

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sector_reg <= sector_in;
            a_reg      <= a_next;
            b_reg      <= b_next;
            duty_reg   <= duty_in;
        end
    end

    assign out_valid  = valid_reg;
    assign sector_out = sector_reg;
    assign term_a     = a_reg;
    assign term_b     = b_reg;
    assign duty_out   = duty_reg;

endmodule

/* src/svpwm_factor_stage.sv */
// Third pipeline stage: long, middle and short factors routed to the phases.
module svpwm_factor_stage import svpwm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sector_t             sector_in,
    input  logic [SINE_W-1:0]   term_a,
    input  logic [SINE_W-1:0]   term_b,
    input  logic [CLAMP_W-1:0]  duty_in,
    output logic                out_valid,
    input  logic                out_ready,
    output sector_t             sector_out,
    output logic [FACTOR_W-1:0] coef_a,
    output logic [FACTOR_W-1:0] coef_b,
    output logic [FACTOR_W-1:0] coef_c,
    output logic [CLAMP_W-1:0]  duty_out
);

    logic                valid_reg;
    sector_t             sector_reg;
    logic [CLAMP_W-1:0]  duty_reg;
    logic [FACTOR_W-1:0] fa_reg, fa_next;
    logic [FACTOR_W-1:0] fb_reg, fb_next;
    logic [FACTOR_W-1:0] fc_reg, fc_next;
    logic [FACTOR_W-1:0] sum;
    logic [FACTOR_W-1:0] first;
    logic [FACTOR_W-1:0] second;
    logic [FACTOR_W-1:0] long_f;
    logic [FACTOR_W-1:0] mid_f;
    logic [FACTOR_W-1:0] short_f;

    always_comb begin
        sum = FACTOR_W'(term_a) + FACTOR_W'(term_b);
        if (sector_in[0]) begin
            first  = FACTOR_W'(term_b);
            second = FACTOR_W'(term_a);
        end else begin
            first  = FACTOR_W'(term_a);
            second = FACTOR_W'(term_b);
        end
        long_f  = ((HALF_Q17 + sum) > ONE_Q17) ? ONE_Q17 : (HALF_Q17 + sum);
        short_f = (sum >= HALF_Q17) ? '0 : (HALF_Q17 - sum);
        mid_f   = HALF_Q17 + second - first;
        case (sector_in)
            SECTOR_I: begin
                fa_next = long_f;  fb_next = mid_f;   fc_next = short_f;
            end
            SECTOR_II: begin
                fa_next = mid_f;   fb_next = long_f;  fc_next = short_f;
            end
            SECTOR_III: begin
                fa_next = short_f; fb_next = long_f;  fc_next = mid_f;
            end
            SECTOR_IV: begin
                fa_next = short_f; fb_next = mid_f;   fc_next = long_f;
            end
            SECTOR_V: begin
                fa_next = mid_f;   fb_next = short_f; fc_next = long_f;
            end
            default: begin
                fa_next = long_f;  fb_next = short_f; fc_next = mid_f;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sector_reg <= sector_in;
            duty_reg   <= duty_in;
            fa_reg     <= fa_next;
            fb_reg     <= fb_next;
            fc_reg     <= fc_next;
        end
    end

    assign out_valid  = valid_reg;
    assign sector_out = sector_reg;
    assign coef_a     = fa_reg;
    assign coef_b     = fb_reg;
    assign coef_c     = fc_reg;
    assign duty_out   = duty_reg;

endmodule

/* src/svpwm_scale_stage.sv */
// Last pipeline stage: factor times duty with rounding (zero while disabled), and the output register.
module svpwm_scale_stage import svpwm_pkg::*; #(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 enable,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sector_t              sector_in,
    input  logic [FACTOR_W-1:0]  coef_a,
    input  logic [FACTOR_W-1:0]  coef_b,
    input  logic [FACTOR_W-1:0]  coef_c,
    input  logic [CLAMP_W-1:0]   duty_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sector_t              sector_out,
    output logic [DUTY_BITS-1:0] duty_a,
    output logic [DUTY_BITS-1:0] duty_b,
    output logic [DUTY_BITS-1:0] duty_c
);

    localparam int PRW = FACTOR_W + CLAMP_W + DUTY_BITS;
    localparam logic [PRW-1:0] ROUND_HALF = PRW'(65536);

    logic                 valid_reg;
    sector_t              sector_reg;
    logic [DUTY_BITS-1:0] da_reg, da_next;
    logic [DUTY_BITS-1:0] db_reg, db_next;
    logic [DUTY_BITS-1:0] dc_reg, dc_next;
    logic [PRW-1:0]       prod_a;
    logic [PRW-1:0]       prod_b;
    logic [PRW-1:0]       prod_c;

    assign prod_a = PRW'(coef_a) * PRW'(duty_in) + ROUND_HALF;
    assign prod_b = PRW'(coef_b) * PRW'(duty_in) + ROUND_HALF;
    assign prod_c = PRW'(coef_c) * PRW'(duty_in) + ROUND_HALF;

    assign da_next = enable ? prod_a[17 +: DUTY_BITS] : '0;
    assign db_next = enable ? prod_b[17 +: DUTY_BITS] : '0;
    assign dc_next = enable ? prod_c[17 +: DUTY_BITS] : '0;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sector_reg <= sector_in;
            da_reg     <= da_next;
            db_reg     <= db_next;
            dc_reg     <= dc_next;
        end
    end

    assign out_valid  = valid_reg;
    assign sector_out = sector_reg;
    assign duty_a     = da_reg;
    assign duty_b     = db_reg;
    assign duty_c     = dc_reg;

endmodule

/* src/svpwm_phase_duty_generator_core.sv */
// Top level of the space-vector PWM phase duty generator.
// The block turns an electrical angle and a duty request into three phase compare values
// and the sector number. It is a four-stage pipeline (sector and clamp, sine table lookup,
// factor routing, multiply and round) that accepts one request every clock cycle while
// the output takes results; output back-pressure stalls the stages in turn without
// losing requests. The sine table is constant logic built at elaboration, so no
// clearing pass follows reset. Writes to enable and max_duty take effect at once and
// should be made only while no request is in flight.
`include "svpwm_phase_duty_generator_core_defines.svh"

module svpwm_phase_duty_generator_core import svpwm_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
    parameter int DUTY_BITS        = DUTY_BITS_DEF,
    localparam int S_TDATA_W = ((ANGLE_BITS + REQ_W + 7) / 8) * 8,
    localparam int M_TDATA_W = ((3 * DUTY_BITS + 3 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // elec_angle, duty_request
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // duty_a, duty_b, duty_c, sector
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  cfg_index_t           cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic               enable_reg;
    logic [CLAMP_W-1:0] max_duty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            max_duty_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENABLE:   enable_reg   <= cfg_wdata[0];
                REG_MAX_DUTY: max_duty_reg <= cfg_wdata[CLAMP_W-1:0];
                default:      ;
            endcase
        end
    end

    logic                  s1_valid, s1_ready;
    sector_t               s1_sector;
    logic [ANGLE_BITS-1:0] s1_rem;
    logic [CLAMP_W-1:0]    s1_duty;

    svpwm_angle_stage #(
        .ANGLE_BITS(ANGLE_BITS),
        .DUTY_BITS (DUTY_BITS)
    ) u_angle (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .angle_in    (s_tdata[ANGLE_BITS-1:0]),
        .duty_request(s_tdata[ANGLE_BITS +: REQ_W]),
        .max_duty    (max_duty_reg),
        .out_valid   (s1_valid),
        .out_ready   (s1_ready),
        .sector      (s1_sector),
        .theta_rem   (s1_rem),
        .duty_clamped(s1_duty)
    );

    logic               s2_valid, s2_ready;
    sector_t            s2_sector;
    logic [SINE_W-1:0]  s2_a, s2_b;
    logic [CLAMP_W-1:0] s2_duty;

    svpwm_sine_lookup #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .ANGLE_BITS      (ANGLE_BITS)
    ) u_lookup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .sector_in (s1_sector),
        .theta_rem (s1_rem),
        .duty_in   (s1_duty),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .sector_out(s2_sector),
        .term_a    (s2_a),
        .term_b    (s2_b),
        .duty_out  (s2_duty)
    );

    logic                s3_valid, s3_ready;
    sector_t             s3_sector;
    logic [FACTOR_W-1:0] s3_fa, s3_fb, s3_fc;
    logic [CLAMP_W-1:0]  s3_duty;

    svpwm_factor_stage u_factor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .sector_in (s2_sector),
        .term_a    (s2_a),
        .term_b    (s2_b),
        .duty_in   (s2_duty),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .sector_out(s3_sector),
        .coef_a    (s3_fa),
        .coef_b    (s3_fb),
        .coef_c    (s3_fc),
        .duty_out  (s3_duty)
    );

    sector_t              out_sector;
    logic [DUTY_BITS-1:0] out_a, out_b, out_c;

    svpwm_scale_stage #(
        .DUTY_BITS(DUTY_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable_reg),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .sector_in (s3_sector),
        .coef_a    (s3_fa),
        .coef_b    (s3_fb),
        .coef_c    (s3_fc),
        .duty_in   (s3_duty),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sector_out(out_sector),
        .duty_a    (out_a),
        .duty_b    (out_b),
        .duty_c    (out_c)
    );

    assign m_tdata = M_TDATA_W'({out_sector, out_c, out_b, out_a});

    logic disabled_out;
    logic duties_zero;

    assign disabled_out = m_tvalid && !enable_reg;
    assign duties_zero  = ({out_a, out_b, out_c} == '0);

    `SVPWM_ASSERT(a_sector_range, m_tvalid |-> (out_sector <= SECTOR_VI), "sector out of range")
    `SVPWM_ASSERT(a_disabled_zero, disabled_out |-> duties_zero, "nonzero duty while disabled")
    `SVPWM_ASSERT_ALWAYS(a_empty_accepts, !m_tvalid |-> s_tready, "stalled while output empty")

endmodule

/* sim/tb.sv */
// Self-checking testbench for the SVPWM phase duty generator core.
`timescale 1ns / 100ps

module tb;
    import svpwm_pkg::*;

    localparam int S_TDATA_W     = ((ANGLE_BITS_DEF + REQ_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((3 * DUTY_BITS_DEF + 3 + 7) / 8) * 8;
    localparam int TABLE_LAST    = 256;
    localparam longint unsigned PI_BY_3_Q30 = 64'd1124419809;
    localparam int DIRECTED_ROWS = 29;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 166;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        sector_t     sector;
    } duty_result_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] angle;
        logic [16:0] request;
        logic        zero_known;
        sector_t     zero_sector;
        cfg_index_t  reg_idx;
        logic [15:0] reg_value;
    } stim_row_t;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    cfg_index_t           cfg_index = REG_ENABLE;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    logic [15:0]  sine_q16 [0:TABLE_LAST];
    logic         cfg_enable   = 1'b0;
    logic [15:0]  cfg_max_duty = 16'hFFFF;
    idle_mode_t   idle_mode    = IDLE_NONE;
    logic         zero_known   = 1'b0;
    sector_t      zero_sector  = SECTOR_I;
    duty_result_t pending_duties [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;

    // Directed requests and register writes: rows with zero_known set expect zero duties and only the given sector.
    stim_row_t directed [DIRECTED_ROWS] = '{
        '{ROW_ITEM,  16'd0,     17'd65535,  1'b1, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd65535, 17'h1FFFF,  1'b1, SECTOR_VI,  REG_ENABLE,   16'd0},
        '{ROW_WRITE, 16'd0,     17'd0,      1'b0, SECTOR_I,   REG_ENABLE,   16'd1},
        '{ROW_ITEM,  16'd0,     17'd0,      1'b1, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd0,     17'd65535,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd65535, 17'd65535,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd10922, 17'd40000,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd10923, 17'd40000,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd21845, 17'd50000,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd21846, 17'd50000,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd32767, 17'd65535,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd32768, 17'd65535,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd43690, 17'd20000,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd43691, 17'd20000,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd54613, 17'd65535,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd54614, 17'd65535,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd16384, 17'd65535,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd49152, 17'd65535,  1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd30000, 17'h10000,  1'b1, SECTOR_III, REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd30000, 17'h18000,  1'b1, SECTOR_III, REG_ENABLE,   16'd0},
        '{ROW_WRITE, 16'd0,     17'd0,      1'b0, SECTOR_I,   REG_MAX_DUTY, 16'd1000},
        '{ROW_ITEM,  16'd5000,  17'd5000,   1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd5000,  17'd1000,   1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_WRITE, 16'd0,     17'd0,      1'b0, SECTOR_I,   REG_MAX_DUTY, 16'd0},
        '{ROW_ITEM,  16'd20000, 17'd65535,  1'b1, SECTOR_II,  REG_ENABLE,   16'd0},
        '{ROW_WRITE, 16'd0,     17'd0,      1'b0, SECTOR_I,   REG_MAX_DUTY, 16'hFFFF},
        '{ROW_WRITE, 16'd0,     17'd0,      1'b0, SECTOR_I,   REG_ENABLE,   16'd0},
        '{ROW_ITEM,  16'd40000, 17'd30000,  1'b1, SECTOR_IV,  REG_ENABLE,   16'd0},
        '{ROW_WRITE, 16'd0,     17'd0,      1'b0, SECTOR_I,   REG_ENABLE,   16'd1}
    };

    svpwm_phase_duty_generator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Sine of i/256 of sixty degrees in Q16, from a truncated odd power series.
    function automatic logic [15:0] sine_entry(input int unsigned i);
        longint unsigned x;
        longint unsigned x_sq;
        longint unsigned term;
        longint unsigned acc;
        x    = (longint'(i) * PI_BY_3_Q30) / TABLE_LAST;
        x_sq = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int m = 1; m <= 4; m++) begin
            term = ((term * x_sq) >> 30) / longint'((2 * m) * (2 * m + 1));
            if (m % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return 16'((acc + 64'd8192) >> 14);
    endfunction

    function automatic logic [15:0] scale_duty(input int unsigned factor, input int unsigned d);
        longint unsigned prod;
        prod = (longint'(factor) * longint'(d) + 64'd65536) >> 17;
        return prod[15:0];
    endfunction

    function automatic duty_result_t predict_duties(input logic [15:0] angle,
                                                    input logic [16:0] request);
        duty_result_t res;
        int unsigned  six;
        int unsigned  k;
        int unsigned  r;
        int unsigned  a;
        int unsigned  b;
        int unsigned  lead;
        int unsigned  trail;
        int unsigned  sum;
        int unsigned  f_long;
        int unsigned  f_mid;
        int unsigned  f_short;
        int unsigned  fa;
        int unsigned  fb;
        int unsigned  fc;
        int unsigned  d;
        six = int'(angle) * 6;
        k   = six >> 16;
        r   = six - (k << 16);
        b   = sine_q16[(r * TABLE_LAST) >> 16];
        a   = sine_q16[((32'd65536 - r) * TABLE_LAST) >> 16];
        if (k % 2 == 1) begin
            lead  = b;
            trail = a;
        end else begin
            lead  = a;
            trail = b;
        end
        sum     = a + b;
        f_long  = (sum > 32'd65536) ? 32'd131072 : 32'd65536 + sum;
        f_short = (sum >= 32'd65536) ? 32'd0 : 32'd65536 - sum;
        f_mid   = 32'd65536 + trail - lead;
        case (sector_t'(k))
            SECTOR_I: begin
                fa = f_long;  fb = f_mid;   fc = f_short;
            end
            SECTOR_II: begin
                fb = f_long;  fa = f_mid;   fc = f_short;
            end
            SECTOR_III: begin
                fb = f_long;  fc = f_mid;   fa = f_short;
            end
            SECTOR_IV: begin
                fc = f_long;  fb = f_mid;   fa = f_short;
            end
            SECTOR_V: begin
                fc = f_long;  fa = f_mid;   fb = f_short;
            end
            default: begin
                fa = f_long;  fc = f_mid;   fb = f_short;
            end
        endcase
        d = request[16] ? 0 : int'(request[15:0]);
        if (d > cfg_max_duty) begin
            d = cfg_max_duty;
        end
        res.sector = sector_t'(k);
        if (cfg_enable) begin
            res.duty_a = scale_duty(fa, d);
            res.duty_b = scale_duty(fb, d);
            res.duty_c = scale_duty(fc, d);
        end else begin
            res.duty_a = '0;
            res.duty_b = '0;
            res.duty_c = '0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Input requests are predicted before the result side is checked at the same edge.
    always @(posedge aclk) begin
        duty_result_t got;
        duty_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (zero_known) begin
                    pending_duties.push_back('{16'd0, 16'd0, 16'd0, zero_sector});
                end else begin
                    pending_duties.push_back(predict_duties(s_tdata[15:0], s_tdata[32:16]));
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[50:48]};
                if (pending_duties.size() == 0) begin
                    report_mismatch("unexpected result, sector", got.sector, -1);
                end else begin
                    want = pending_duties.pop_front();
                    if (got.duty_a !== want.duty_a) begin
                        report_mismatch("duty_a", got.duty_a, want.duty_a);
                    end
                    if (got.duty_b !== want.duty_b) begin
                        report_mismatch("duty_b", got.duty_b, want.duty_b);
                    end
                    if (got.duty_c !== want.duty_c) begin
                        report_mismatch("duty_c", got.duty_c, want.duty_c);
                    end
                    if (got.sector !== want.sector) begin
                        report_mismatch("sector", got.sector, want.sector);
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_tready <= ($urandom_range(99) >= 82);
            IDLE_BOTH:     m_tready <= ($urandom_range(99) >= 18);
            default:       m_tready <= 1'b1;
        endcase
    end

    function automatic logic sender_rests();
        case (idle_mode)
            IDLE_SENDER: return ($urandom_range(99) < 82);
            IDLE_BOTH:   return ($urandom_range(99) < 18);
            default:     return 1'b0;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic [15:0] angle, input logic [16:0] request,
                                input logic known, input sector_t known_sector);
        while (sender_rests()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {7'($urandom), request, angle};
        zero_known  <= known;
        zero_sector <= known_sector;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_ENABLE) begin
            cfg_enable = value[0];
        end else begin
            cfg_max_duty = value;
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_duties.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [15:0] angle;
        logic [16:0] request;
        logic [15:0] new_max;
        int          pick;
        int          near;
        for (int i = 0; i <= TABLE_LAST; i++) begin
            sine_q16[i] = sine_entry(i);
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed[i].kind == ROW_WRITE) begin
                settle();
                write_reg(directed[i].reg_idx, directed[i].reg_value);
            end else begin
                send_request(directed[i].angle, directed[i].request,
                             directed[i].zero_known, directed[i].zero_sector);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            idle_mode <= idle_mode_t'(phase % 4);
            case (phase)
                0, 6:    new_max = 16'hFFFF;
                2:       new_max = 16'd0;
                4:       new_max = 16'd1;
                default: new_max = 16'($urandom_range(65535));
            endcase
            write_reg(REG_ENABLE, (phase == 3) ? 16'd0 : 16'd1);
            write_reg(REG_MAX_DUTY, new_max);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(7) == 0) begin
                    pick  = $urandom_range(5, 1);
                    angle = 16'((pick * 65536 + 5) / 6 + $urandom_range(6) - 3);
                end else begin
                    angle = 16'($urandom);
                end
                pick = $urandom_range(99);
                if (pick < 50) begin
                    request = {1'b0, 16'($urandom)};
                end else if (pick < 70) begin
                    near    = int'(cfg_max_duty) + int'($urandom_range(4)) - 2;
                    request = near[16:0];
                end else if (pick < 85) begin
                    request = {1'b1, 16'($urandom)};
                end else begin
                    request = ($urandom_range(1) == 0) ? 17'd0 : 17'd65535;
                end
                send_request(angle, request, 1'b0, SECTOR_I);
            end
        end

        settle();
        if (mismatch_count == 0 && pending_duties.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/svpwm_pkg.sv
src/svpwm_angle_stage.sv
src/svpwm_sine_lookup.sv
src/svpwm_factor_stage.sv
src/svpwm_scale_stage.sv
src/svpwm_phase_duty_generator_core.sv
sim/tb.sv
